// ===== hdl/stt_pkg.sv =====
// shared types and token kind codes for the source text tokenizer
// no dependencies
`timescale 1ns / 1ps

package stt_pkg;

   localparam logic [5:0] K_EOF       = 6'd0;
   localparam logic [5:0] K_IDENT     = 6'd1;
   localparam logic [5:0] K_KEYWORD0  = 6'd2;
   localparam logic [5:0] K_INT_LIT   = 6'd16;
   localparam logic [5:0] K_FLOAT_LIT = 6'd17;
   localparam logic [5:0] K_STR_LIT   = 6'd18;
   localparam logic [5:0] K_BAD       = 6'd19;
   localparam logic [5:0] K_UNTERM    = 6'd20;
   localparam logic [5:0] K_ASSIGN    = 6'd21;
   localparam logic [5:0] K_EQ        = 6'd22;
   localparam logic [5:0] K_NOT       = 6'd23;
   localparam logic [5:0] K_NE        = 6'd24;
   localparam logic [5:0] K_LT        = 6'd25;
   localparam logic [5:0] K_LE        = 6'd26;
   localparam logic [5:0] K_GT        = 6'd27;
   localparam logic [5:0] K_GE        = 6'd28;
   localparam logic [5:0] K_AND       = 6'd29;
   localparam logic [5:0] K_OR        = 6'd30;
   localparam logic [5:0] K_PLUS      = 6'd31;
   localparam logic [5:0] K_MINUS     = 6'd32;
   localparam logic [5:0] K_STAR      = 6'd33;
   localparam logic [5:0] K_SLASH     = 6'd34;
   localparam logic [5:0] K_PERCENT   = 6'd35;
   localparam logic [5:0] K_LPAREN    = 6'd36;
   localparam logic [5:0] K_RPAREN    = 6'd37;
   localparam logic [5:0] K_LBRACE    = 6'd38;
   localparam logic [5:0] K_RBRACE    = 6'd39;
   localparam logic [5:0] K_LBRACK    = 6'd40;
   localparam logic [5:0] K_RBRACK    = 6'd41;
   localparam logic [5:0] K_SEMI      = 6'd42;
   localparam logic [5:0] K_COMMA     = 6'd43;
   localparam logic [5:0] K_DOT       = 6'd44;
   localparam logic [5:0] K_LAST      = K_DOT;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [19:0] token_line;
      logic [15:0] token_column;
      logic [15:0] token_length;
      logic [7:0]  error_byte;
      logic        last_of_text;
   } result_type;

   // up to three results caused by one input byte
   typedef struct packed {
      logic [1:0]           count;
      result_type [2:0]     res;
   } bundle_type;

endpackage

// ===== hdl/stt_if.sv =====
// channel interfaces: source bytes in, tokens out
// depends on nothing
`timescale 1ns / 1ps

interface stt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_byte;
   logic       end_of_text;
   modport source (output valid, output char_byte, output end_of_text, input ready);
   modport sink (input valid, input char_byte, input end_of_text, output ready);
endinterface

interface stt_rsp_if;
   logic        valid;
   logic        ready;
   logic [5:0]  token_kind;
   logic [19:0] token_line;
   logic [15:0] token_column;
   logic [15:0] token_length;
   logic [7:0]  error_byte;
   logic        last_of_text;
   modport source (output valid, output token_kind, output token_line, output token_column,
                   output token_length, output error_byte, output last_of_text,
                   input ready);
   modport sink (input valid, input token_kind, input token_line, input token_column,
                 input token_length, input error_byte, input last_of_text,
                 output ready);
endinterface

// ===== hdl/source_text_tokenizer.sv =====
// tokenizer top: one source byte per cycle in while the queue has room,
// one token word per cycle out while the sink is ready; results wait in the queue
// throughput: one byte per cycle while the queue is not full; a byte causing two
//   or three results holds its bundle in the four-entry queue until all are taken
// reset: synchronous; empties the queue, position back to line 1 column 1
`timescale 1ns / 1ps

module source_text_tokenizer #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16,
   parameter int KEYWORD_MAX = 8
) (
   input logic       clock,
   input logic       reset,
   stt_req_if.sink   req_chan,
   stt_rsp_if.source rsp_chan
);
   import stt_pkg::*;

   bundle_type bundle, head;
   logic       take, push, pop, head_valid, full;

   assign req_chan.ready = !full;
   assign take = req_chan.valid && !full;
   assign push = take && (bundle.count != 2'd0);

   stt_front #(
      .LINE_BITS(LINE_BITS),
      .COLUMN_BITS(COLUMN_BITS),
      .KEYWORD_MAX(KEYWORD_MAX)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .take(take),
      .char_byte(req_chan.char_byte),
      .end_of_text(req_chan.end_of_text),
      .bundle(bundle)
   );

   stt_fifo #(
      .WIDTH($bits(bundle_type)),
      .DEPTH(4)
   ) u_fifo (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(bundle),
      .pop(pop),
      .head_data(head),
      .head_valid(head_valid),
      .full(full)
   );

   stt_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .head_valid(head_valid),
      .pop(pop),
      .rsp_chan(rsp_chan)
   );

   // checks
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("bundle pushed into full queue");
   a_last_is_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.last_of_text == (rsp_chan.token_kind == K_EOF)))
      else $error("end flag and eof kind disagree");
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.token_kind <= K_LAST)
      else $error("token kind out of range");
   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid && head.count != 2'd0)
      else $error("pop from empty or null bundle");

endmodule

// ===== hdl/stt_front.sv =====
// lexer front end: mode machine, position counters, keyword match
// builds one bundle of results per accepted byte; uses stt_pkg
`timescale 1ns / 1ps

module stt_front #(
   parameter int LINE_BITS   = 20,
   parameter int COLUMN_BITS = 16,
   parameter int KEYWORD_MAX = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         char_byte,
   input  logic               end_of_text,
   output stt_pkg::bundle_type bundle
);
   import stt_pkg::*;

   localparam int KW_IDX_BITS = $clog2(KEYWORD_MAX);
   localparam int KW_COUNT = 14;
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      64'("int"), 64'("float"), 64'("string"), 64'("bool"), 64'("void"),
      64'("true"), 64'("false"), 64'("function"), 64'("return"), 64'("if"),
      64'("else"), 64'("while"), 64'("for"), 64'("print")};
   localparam int KW_LEN [KW_COUNT] = '{3, 5, 6, 4, 4, 4, 5, 8, 6, 2, 4, 5, 3, 5};

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UND   = 8'h5F;

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FLOAT, M_STRING, M_STRING_ESC, M_OP, M_COMMENT
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in, start_ff, start_in, len_ff, len_in;
   logic [7:0]             pend_ff, pend_in;
   logic [7:0]             kw_buf_ff [KEYWORD_MAX];
   logic                   kw_we;
   logic [KW_IDX_BITS-1:0] kw_idx;

   logic [7:0]             c;
   logic                   is_end, do_flush, fresh, s_val;
   logic [1:0]             fl_cnt, f_cnt;
   result_type             fl0, fl1, s0;
   logic [5:0]             id_kind, lone_kind, single_kind;
   logic [COLUMN_BITS-1:0] dot_col;

   function automatic logic [COLUMN_BITS-1:0] col_sat(input logic [COLUMN_BITS-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic result_type mk(input logic [5:0] kind,
                                     input logic [LINE_BITS-1:0] line,
                                     input logic [COLUMN_BITS-1:0] col,
                                     input logic [COLUMN_BITS-1:0] len,
                                     input logic [7:0] err, input logic last);
      result_type r;
      r.token_kind   = kind;
      r.token_line   = 20'(line);
      r.token_column = 16'(col);
      r.token_length = 16'(len);
      r.error_byte   = err;
      r.last_of_text = last;
      return r;
   endfunction

   function automatic logic is_alpha(input logic [7:0] v);
      return (v >= 8'h61 && v <= 8'h7A) || (v >= 8'h41 && v <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] v);
      return v >= 8'h30 && v <= 8'h39;
   endfunction

   function automatic logic is_space(input logic [7:0] v);
      return v == 8'h20 || (v >= 8'h09 && v <= 8'h0D);
   endfunction

   function automatic logic may_pair(input logic [7:0] v);
      return v == 8'h3D || v == 8'h21 || v == 8'h3C || v == 8'h3E || v == 8'h26 ||
             v == 8'h7C || v == 8'h2F;
   endfunction

   // keyword compare against the stored identifier
   always_comb begin
      logic        hit;
      logic [63:0] kw_left;
      id_kind = K_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         hit = (len_ff == COLUMN_BITS'(KW_LEN[i]));
         // keyword text left aligned, first byte on top
         kw_left = KW_TEXT[i] << (8 * (8 - KW_LEN[i]));
         for (int j = 0; j < 8; j++) begin
            if (j < KW_LEN[i] && kw_buf_ff[j] != kw_left[8*(7-j) +: 8]) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            id_kind = K_KEYWORD0 + 6'(i);
         end
      end
   end

   // kind of a lone pending operator
   always_comb begin
      unique case (pend_ff)
         8'h3D:   lone_kind = K_ASSIGN;
         8'h21:   lone_kind = K_NOT;
         8'h3C:   lone_kind = K_LT;
         8'h3E:   lone_kind = K_GT;
         8'h2F:   lone_kind = K_SLASH;
         default: lone_kind = K_BAD;
      endcase
   end

   // kind of a byte that never pairs
   always_comb begin
      unique case (c)
         8'h2B:   single_kind = K_PLUS;
         8'h2D:   single_kind = K_MINUS;
         8'h2A:   single_kind = K_STAR;
         8'h25:   single_kind = K_PERCENT;
         8'h28:   single_kind = K_LPAREN;
         8'h29:   single_kind = K_RPAREN;
         8'h7B:   single_kind = K_LBRACE;
         8'h7D:   single_kind = K_RBRACE;
         8'h5B:   single_kind = K_LBRACK;
         8'h5D:   single_kind = K_RBRACK;
         8'h3B:   single_kind = K_SEMI;
         8'h2C:   single_kind = K_COMMA;
         8'h2E:   single_kind = K_DOT;
         default: single_kind = K_BAD;
      endcase
   end

   // results of flushing the pending token
   always_comb begin
      dot_col = ((&col_ff) || col_ff < COLUMN_BITS'(2)) ? col_ff : col_ff - 1'b1;
      fl_cnt = 2'd0;
      fl0 = '0;
      fl1 = '0;
      unique case (mode_ff)
         M_IDENT: begin
            fl_cnt = 2'd1;
            fl0 = mk(id_kind, line_ff, start_ff, len_ff, 8'd0, 1'b0);
         end
         M_INT: begin
            fl_cnt = 2'd1;
            fl0 = mk(K_INT_LIT, line_ff, start_ff, len_ff, 8'd0, 1'b0);
         end
         M_INT_DOT: begin
            fl_cnt = 2'd2;
            fl0 = mk(K_INT_LIT, line_ff, start_ff, len_ff, 8'd0, 1'b0);
            fl1 = mk(K_DOT, line_ff, dot_col, COLUMN_BITS'(1), 8'd0, 1'b0);
         end
         M_FLOAT: begin
            fl_cnt = 2'd1;
            fl0 = mk(K_FLOAT_LIT, line_ff, start_ff, len_ff, 8'd0, 1'b0);
         end
         M_STRING, M_STRING_ESC: begin
            fl_cnt = 2'd1;
            fl0 = mk(K_UNTERM, line_ff, start_ff, len_ff, 8'd0, 1'b0);
         end
         M_OP: begin
            fl_cnt = 2'd1;
            fl0 = mk(lone_kind, line_ff, start_ff, COLUMN_BITS'(1),
                     (lone_kind == K_BAD) ? pend_ff : 8'd0, 1'b0);
         end
         default: ;
      endcase
   end

   // next state for one byte
   always_comb begin
      c = char_byte;
      is_end = end_of_text || (c == 8'd0);
      mode_in = mode_ff;
      line_in = line_ff;
      col_in = col_ff;
      start_in = start_ff;
      len_in = len_ff;
      pend_in = pend_ff;
      kw_we = 1'b0;
      kw_idx = len_ff[KW_IDX_BITS-1:0];
      do_flush = 1'b0;
      fresh = 1'b0;
      s_val = 1'b0;
      s0 = '0;
      if (is_end) begin
         do_flush = 1'b1;
         s_val = 1'b1;
         s0 = mk(K_EOF, line_ff, col_ff, '0, 8'd0, 1'b1);
         mode_in = M_IDLE;
         line_in = LINE_BITS'(1);
         col_in = COLUMN_BITS'(1);
         start_in = COLUMN_BITS'(1);
         len_in = '0;
         pend_in = 8'd0;
      end else begin
         unique case (mode_ff)
            M_COMMENT: begin
               if (c == CH_NL) mode_in = M_IDLE;
            end
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c) || c == CH_UND) begin
                  kw_we = (len_ff < COLUMN_BITS'(KEYWORD_MAX));
                  len_in = col_sat(len_ff);
               end else begin
                  do_flush = 1'b1;
                  fresh = 1'b1;
               end
            end
            M_INT: begin
               if (is_digit(c)) len_in = col_sat(len_ff);
               else if (c == CH_DOT) mode_in = M_INT_DOT;
               else begin
                  do_flush = 1'b1;
                  fresh = 1'b1;
               end
            end
            M_INT_DOT: begin
               if (is_digit(c)) begin
                  len_in = col_sat(col_sat(len_ff));
                  mode_in = M_FLOAT;
               end else begin
                  do_flush = 1'b1;
                  fresh = 1'b1;
               end
            end
            M_FLOAT: begin
               if (is_digit(c)) len_in = col_sat(len_ff);
               else begin
                  do_flush = 1'b1;
                  fresh = 1'b1;
               end
            end
            M_STRING: begin
               if (c == CH_QUOTE) begin
                  s_val = 1'b1;
                  s0 = mk(K_STR_LIT, line_ff, start_ff, len_ff, 8'd0, 1'b0);
                  mode_in = M_IDLE;
               end else begin
                  if (c == CH_BSL) mode_in = M_STRING_ESC;
                  len_in = col_sat(len_ff);
               end
            end
            M_STRING_ESC: begin
               len_in = col_sat(len_ff);
               mode_in = M_STRING;
            end
            M_OP: begin
               if (pend_ff == CH_SLASH && c == CH_SLASH) begin
                  mode_in = M_COMMENT;
               end else if (c == CH_EQ && (pend_ff == 8'h3D || pend_ff == 8'h21 ||
                                           pend_ff == 8'h3C || pend_ff == 8'h3E)) begin
                  s_val = 1'b1;
                  s0 = mk(lone_kind + 6'd1, line_ff, start_ff, COLUMN_BITS'(2), 8'd0, 1'b0);
                  mode_in = M_IDLE;
               end else if ((pend_ff == 8'h26 && c == 8'h26) ||
                            (pend_ff == 8'h7C && c == 8'h7C)) begin
                  s_val = 1'b1;
                  s0 = mk((pend_ff == 8'h26) ? K_AND : K_OR, line_ff, start_ff,
                          COLUMN_BITS'(2), 8'd0, 1'b0);
                  mode_in = M_IDLE;
               end else begin
                  do_flush = 1'b1;
                  fresh = 1'b1;
               end
            end
            default: begin
               fresh = 1'b1;
            end
         endcase

         // a byte that begins a new token
         if (fresh) begin
            mode_in = M_IDLE;
            if (!is_space(c)) begin
               start_in = col_ff;
               if (is_alpha(c) || c == CH_UND) begin
                  mode_in = M_IDENT;
                  kw_we = 1'b1;
                  kw_idx = '0;
                  len_in = COLUMN_BITS'(1);
               end else if (is_digit(c)) begin
                  mode_in = M_INT;
                  len_in = COLUMN_BITS'(1);
               end else if (c == CH_QUOTE) begin
                  mode_in = M_STRING;
                  start_in = col_sat(col_ff);
                  len_in = '0;
               end else if (may_pair(c)) begin
                  mode_in = M_OP;
                  pend_in = c;
               end else begin
                  s_val = 1'b1;
                  s0 = mk(single_kind, line_ff, col_ff, COLUMN_BITS'(1),
                          (single_kind == K_BAD) ? c : 8'd0, 1'b0);
               end
            end
         end

         // position update
         if (c == CH_NL) begin
            line_in = (&line_ff) ? line_ff : line_ff + 1'b1;
            col_in = COLUMN_BITS'(1);
         end else begin
            col_in = col_sat(col_ff);
         end
      end

      // pack flush results ahead of the new one
      f_cnt = do_flush ? fl_cnt : 2'd0;
      bundle.count = f_cnt + {1'b0, s_val};
      bundle.res[0] = (f_cnt != 2'd0) ? fl0 : s0;
      bundle.res[1] = (f_cnt == 2'd2) ? fl1 : s0;
      bundle.res[2] = s0;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         line_ff <= LINE_BITS'(1);
         col_ff <= COLUMN_BITS'(1);
         start_ff <= COLUMN_BITS'(1);
         len_ff <= '0;
         pend_ff <= 8'd0;
      end else if (take) begin
         mode_ff <= mode_in;
         line_ff <= line_in;
         col_ff <= col_in;
         start_ff <= start_in;
         len_ff <= len_in;
         pend_ff <= pend_in;
      end
   end

   // identifier text, read only where written
   always_ff @(posedge clock) begin
      if (take && !is_end && kw_we) begin
         kw_buf_ff[kw_idx] <= c;
      end
   end

endmodule

// ===== hdl/stt_fifo.sv =====
// short queue of result bundles between lexer and output side
// no package dependency
`timescale 1ns / 1ps

module stt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output logic             head_valid,
   output logic             full
);
   localparam int PTR_BITS = $clog2(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ff, rd_ff;
   logic [PTR_BITS:0]   cnt_ff;

   assign head_data  = mem_ff[rd_ff];
   assign head_valid = (cnt_ff != '0);
   assign full       = (cnt_ff == (PTR_BITS+1)'(DEPTH));

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= (wr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (pop) rd_ff <= (rd_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

endmodule

// ===== hdl/stt_back.sv =====
// output side: walks the results of the head bundle one word at a time
// uses stt_pkg and stt_rsp_if
`timescale 1ns / 1ps

module stt_back (
   input  logic                clock,
   input  logic                reset,
   input  stt_pkg::bundle_type head,
   input  logic                head_valid,
   output logic                pop,
   stt_rsp_if.source           rsp_chan
);
   import stt_pkg::*;

   logic [1:0] idx_ff;
   result_type cur;
   logic       take;

   assign cur  = head.res[idx_ff];
   assign take = head_valid && rsp_chan.ready;
   assign pop  = take && (idx_ff == head.count - 2'd1);

   assign rsp_chan.valid        = head_valid;
   assign rsp_chan.token_kind   = cur.token_kind;
   assign rsp_chan.token_line   = cur.token_line;
   assign rsp_chan.token_column = cur.token_column;
   assign rsp_chan.token_length = cur.token_length;
   assign rsp_chan.error_byte   = cur.error_byte;
   assign rsp_chan.last_of_text = cur.last_of_text;

   // result index within the bundle
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else if (take) begin
         idx_ff <= pop ? 2'd0 : idx_ff + 2'd1;
      end
   end

endmodule

// ===== tb/sv/tb_source_text_tokenizer.sv =====
// self-checking testbench for the source text tokenizer
// depends on stt_pkg, stt_if and the source_text_tokenizer rtl
`timescale 1ns / 1ps

module tb_source_text_tokenizer;
   import stt_pkg::*;

   localparam logic [19:0] LINE_TOP = 20'hFFFFF;
   localparam logic [15:0] COL_TOP  = 16'hFFFF;
   localparam int          KW_MAX   = 8;
   localparam longint      CYCLE_LIMIT = 400000;

   typedef enum logic [3:0] {
      LX_IDLE, LX_IDENT, LX_INT, LX_INT_DOT, LX_FLOAT, LX_STRING, LX_STRING_ESC,
      LX_OP, LX_COMMENT
   } lex_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stt_req_if req_chan ();
   stt_rsp_if rsp_chan ();

   source_text_tokenizer i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   // clock generation
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   lex_mode_type mode;
   logic [19:0] line_cnt;
   logic [15:0] col_cnt;
   logic [15:0] tok_col;
   logic [15:0] tok_len;
   logic [7:0]  kw_buf [KW_MAX];
   logic [7:0]  pend_op;

   result_type  token_queue [$];
   int          error_count = 0;
   int          token_count = 0;
   int          byte_count = 0;
   longint      cycle_count = 0;
   int          rsp_hold = 0;
   int          sink_wait = 0;
   bit          rand_sink_gaps = 1'b1;

   function automatic logic [15:0] col_inc(logic [15:0] v);
      return (v == COL_TOP) ? v : v + 16'd1;
   endfunction

   function automatic bit is_digit_b(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha_b(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit is_space_b(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   task automatic push_token(logic [5:0] k, logic [15:0] col, logic [15:0] len,
                             logic [7:0] err, logic last);
      result_type r;
      r.token_kind = k;
      r.token_line = line_cnt;
      r.token_column = col;
      r.token_length = len;
      r.error_byte = err;
      r.last_of_text = last;
      token_queue.push_back(r);
   endtask

   function automatic logic [5:0] keyword_kind();
      string kw [14];
      bit    hit;
      kw = '{"int", "float", "string", "bool", "void", "true", "false", "function",
             "return", "if", "else", "while", "for", "print"};
      for (int i = 0; i < 14; i++) begin
         if (tok_len == kw[i].len() && kw[i].len() <= KW_MAX) begin
            hit = 1'b1;
            for (int j = 0; j < kw[i].len(); j++)
               if (kw_buf[j] != kw[i][j]) hit = 1'b0;
            if (hit) return K_KEYWORD0 + 6'(i);
         end
      end
      return K_IDENT;
   endfunction

   function automatic logic [5:0] single_kind(logic [7:0] c);
      case (c)
         "+": return K_PLUS;
         "-": return K_MINUS;
         "*": return K_STAR;
         "%": return K_PERCENT;
         "(": return K_LPAREN;
         ")": return K_RPAREN;
         "{": return K_LBRACE;
         "}": return K_RBRACE;
         "[": return K_LBRACK;
         "]": return K_RBRACK;
         ";": return K_SEMI;
         ",": return K_COMMA;
         ".": return K_DOT;
         default: return K_EOF;
      endcase
   endfunction

   function automatic bit may_pair(logic [7:0] c);
      return c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|" ||
             c == "/";
   endfunction

   task automatic lexer_reset();
      mode = LX_IDLE;
      line_cnt = 20'd1;
      col_cnt = 16'd1;
      tok_col = 16'd1;
      tok_len = 16'd0;
      pend_op = 8'd0;
      for (int i = 0; i < KW_MAX; i++) kw_buf[i] = 8'd0;
   endtask

   // emit whatever tokens the current mode holds, then go idle
   task automatic flush_pending();
      logic [5:0]  k;
      logic [15:0] dcol;
      case (mode)
         LX_IDENT: push_token(keyword_kind(), tok_col, tok_len, 8'd0, 1'b0);
         LX_INT: push_token(K_INT_LIT, tok_col, tok_len, 8'd0, 1'b0);
         LX_INT_DOT: begin
            push_token(K_INT_LIT, tok_col, tok_len, 8'd0, 1'b0);
            dcol = (col_cnt == COL_TOP || col_cnt < 16'd2) ? col_cnt : col_cnt - 16'd1;
            push_token(K_DOT, dcol, 16'd1, 8'd0, 1'b0);
         end
         LX_FLOAT: push_token(K_FLOAT_LIT, tok_col, tok_len, 8'd0, 1'b0);
         LX_STRING, LX_STRING_ESC: push_token(K_UNTERM, tok_col, tok_len, 8'd0, 1'b0);
         LX_OP: begin
            case (pend_op)
               "=": k = K_ASSIGN;
               "!": k = K_NOT;
               "<": k = K_LT;
               ">": k = K_GT;
               "/": k = K_SLASH;
               default: k = K_BAD;
            endcase
            push_token(k, tok_col, 16'd1, (k == K_BAD) ? pend_op : 8'd0, 1'b0);
         end
         default: ;
      endcase
      mode = LX_IDLE;
   endtask

   task automatic begin_token(logic [7:0] c);
      logic [5:0] k;
      if (is_space_b(c)) return;
      tok_col = col_cnt;
      if (is_alpha_b(c) || c == "_") begin
         mode = LX_IDENT;
         kw_buf[0] = c;
         tok_len = 16'd1;
      end else if (is_digit_b(c)) begin
         mode = LX_INT;
         tok_len = 16'd1;
      end else if (c == "\"") begin
         mode = LX_STRING;
         tok_col = col_inc(col_cnt);
         tok_len = 16'd0;
      end else if (may_pair(c)) begin
         mode = LX_OP;
         pend_op = c;
      end else begin
         k = single_kind(c);
         if (k != K_EOF) push_token(k, tok_col, 16'd1, 8'd0, 1'b0);
         else push_token(K_BAD, tok_col, 16'd1, c, 1'b0);
      end
   endtask

   // predict the tokens caused by one accepted word
   task automatic predict_tokens(logic [7:0] c, logic eot);
      bit fresh;
      fresh = 1'b0;
      if (eot || c == 8'd0) begin
         flush_pending();
         push_token(K_EOF, col_cnt, 16'd0, 8'd0, 1'b1);
         lexer_reset();
         return;
      end
      case (mode)
         LX_COMMENT: if (c == "\n") mode = LX_IDLE;
         LX_IDENT: begin
            if (is_alpha_b(c) || is_digit_b(c) || c == "_") begin
               if (tok_len < KW_MAX) kw_buf[tok_len] = c;
               tok_len = col_inc(tok_len);
            end else begin
               flush_pending();
               fresh = 1'b1;
            end
         end
         LX_INT: begin
            if (is_digit_b(c)) tok_len = col_inc(tok_len);
            else if (c == ".") mode = LX_INT_DOT;
            else begin
               flush_pending();
               fresh = 1'b1;
            end
         end
         LX_INT_DOT: begin
            if (is_digit_b(c)) begin
               tok_len = col_inc(col_inc(tok_len));
               mode = LX_FLOAT;
            end else begin
               flush_pending();
               fresh = 1'b1;
            end
         end
         LX_FLOAT: begin
            if (is_digit_b(c)) tok_len = col_inc(tok_len);
            else begin
               flush_pending();
               fresh = 1'b1;
            end
         end
         LX_STRING: begin
            if (c == "\"") begin
               push_token(K_STR_LIT, tok_col, tok_len, 8'd0, 1'b0);
               mode = LX_IDLE;
            end else begin
               if (c == "\\") mode = LX_STRING_ESC;
               tok_len = col_inc(tok_len);
            end
         end
         LX_STRING_ESC: begin
            tok_len = col_inc(tok_len);
            mode = LX_STRING;
         end
         LX_OP: begin
            if (pend_op == "/" && c == "/") mode = LX_COMMENT;
            else if (c == "=" && (pend_op == "=" || pend_op == "!" || pend_op == "<" ||
                                  pend_op == ">")) begin
               push_token((pend_op == "=") ? K_EQ : (pend_op == "!") ? K_NE :
                          (pend_op == "<") ? K_LE : K_GE, tok_col, 16'd2, 8'd0, 1'b0);
               mode = LX_IDLE;
            end else if ((pend_op == "&" && c == "&") || (pend_op == "|" && c == "|")) begin
               push_token((pend_op == "&") ? K_AND : K_OR, tok_col, 16'd2, 8'd0, 1'b0);
               mode = LX_IDLE;
            end else begin
               flush_pending();
               fresh = 1'b1;
            end
         end
         default: begin
            mode = LX_IDLE;
            fresh = 1'b1;
         end
      endcase
      if (fresh) begin_token(c);
      if (c == "\n") begin
         line_cnt = (line_cnt == LINE_TOP) ? line_cnt : line_cnt + 20'd1;
         col_cnt = 16'd1;
      end else begin
         col_cnt = col_inc(col_cnt);
      end
   endtask

   // send one word, with a random lead-in gap
   task automatic send_byte(logic [7:0] c, logic eot = 1'b0, bit gaps = 1'b1);
      int gap;
      gap = gaps ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.char_byte <= c;
      req_chan.end_of_text <= eot;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_tokens(c, eot);
      byte_count++;
   endtask

   task automatic send_text(string s, bit gaps = 1'b1);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, gaps);
   endtask

   // source goes quiet until every expected word has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (token_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // sink side: a random wait after each accepted word, or a forced stall
   always @(posedge clock) begin
      int w;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         sink_wait <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_chan.valid && rsp_chan.ready) begin
         w = rand_sink_gaps ? $urandom_range(0, 3) : 0;
         sink_wait <= w;
         rsp_chan.ready <= (w == 0);
      end else if (sink_wait > 0) begin
         sink_wait <= sink_wait - 1;
         rsp_chan.ready <= (sink_wait == 1);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      result_type got;
      result_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.token_kind = rsp_chan.token_kind;
         got.token_line = rsp_chan.token_line;
         got.token_column = rsp_chan.token_column;
         got.token_length = rsp_chan.token_length;
         got.error_byte = rsp_chan.error_byte;
         got.last_of_text = rsp_chan.last_of_text;
         token_count++;
         if (token_queue.size() == 0) begin
            $display("%0t: unexpected token, expected none, actual %p", $time, got);
            error_count++;
         end else begin
            want = token_queue.pop_front();
            if (got.token_kind !== want.token_kind) begin
               $display("%0t: token_kind expected %0d actual %0d", $time, want.token_kind,
                        got.token_kind);
               error_count++;
            end
            if (got.token_line !== want.token_line) begin
               $display("%0t: token_line expected %0d actual %0d", $time, want.token_line,
                        got.token_line);
               error_count++;
            end
            if (got.token_column !== want.token_column) begin
               $display("%0t: token_column expected %0d actual %0d", $time,
                        want.token_column, got.token_column);
               error_count++;
            end
            if (got.token_length !== want.token_length) begin
               $display("%0t: token_length expected %0d actual %0d", $time,
                        want.token_length, got.token_length);
               error_count++;
            end
            if (got.error_byte !== want.error_byte) begin
               $display("%0t: error_byte expected %0h actual %0h", $time, want.error_byte,
                        got.error_byte);
               error_count++;
            end
            if (got.last_of_text !== want.last_of_text) begin
               $display("%0t: last_of_text expected %0d actual %0d", $time,
                        want.last_of_text, got.last_of_text);
               error_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("source_text_tokenizer regression: fail");
         $finish;
      end
   end

   // keywords, operators, literals, comments, bad bytes and unterminated strings
   task automatic test_directed();
      send_text("int float string bool void true false function return\n");
      send_text("if else while for print functions x_9 _ Zq\n");
      send_text("= == ! != < <= > >= && || & | + - * / % ( ) { } [ ] ; , .\n");
      send_text("12 3.5 7.x 9. \"a\\\"b\" // note  \n  // more\nk");
      send_byte(8'd0);
      send_text("\x80\xff@#$");
      send_text("\"open\\");
      send_byte(8'h55, 1'b1);
      send_text("5.");
      send_byte(8'd0, 1'b1);
      wait_drained();
   endtask

   // sink holds off while the source keeps offering, then source waits for drain
   task automatic test_backpressure();
      rsp_hold = 60;
      send_text("1.a 2.b 3.c 4.+ 5.; 6.( ab.cd", 1'b0);
      send_byte(8'd0, 1'b1, 1'b0);
      wait_drained();
   endtask

   // long line and long tokens drive column and length up
   task automatic test_long_tokens();
      for (int i = 0; i < 20; i++) send_byte("a", 1'b0, 1'b0);
      send_byte(" ");
      for (int i = 0; i < 12; i++) send_byte("7", 1'b0, 1'b0);
      send_byte(8'd0, 1'b1);
      wait_drained();
   endtask

   function automatic logic [7:0] pick_byte();
      string alpha;
      alpha = "abcfilnprstuvwe_XZ0123456789.\"\\/=!<>&|+-*%(){}[];, \n\t";
      case ($urandom_range(0, 9))
         0: return 8'($urandom_range(1, 255));
         default: return alpha[$urandom_range(0, alpha.len() - 1)];
      endcase
   endfunction

   // random programs: mostly token-shaped text, some noise
   task automatic test_random();
      string frag [12];
      frag = '{"int ", "while(x<=3){", "print(\"hi\\n\");", "y=1.25;", "a&&b||c",
               "// c\n", "return 42;\n", "if(a!=b)", "f.g", "\"s", "9.e", "false "};
      while (byte_count < 360) begin
         if ($urandom_range(0, 3) != 0) send_text(frag[$urandom_range(0, 11)]);
         else send_byte(pick_byte());
         if ($urandom_range(0, 24) == 0) send_byte(8'($urandom), 1'b1);
      end
      send_byte(8'd0, 1'b1);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.char_byte = 8'd0;
      req_chan.end_of_text = 1'b0;
      lexer_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_long_tokens();
      test_random();
      wait_drained();
      repeat (10) @(posedge clock);
      $display("sent %0d bytes, checked %0d tokens across keywords, operators, literals,",
               byte_count, token_count);
      $display("comments, errors and output back-pressure");
      if (error_count == 0 && token_queue.size() == 0) begin
         $display("source_text_tokenizer regression: pass");
      end else begin
         $display("source_text_tokenizer regression: fail");
      end
      $finish;
   end

endmodule
